// ----- hdl/sfl_pkg.sv -----
// Package: payload structs, register indexes, sequencer states and sine table for the flanger.
`default_nettype none
package sfl_pkg;

	// Input transaction payload
	typedef struct packed {
		logic signed [15:0] left_in;
		logic signed [15:0] right_in;
	} sfl_in_t;

	// Output transaction payload
	typedef struct packed {
		logic signed [15:0] left_out;
		logic signed [15:0] right_out;
	} sfl_out_t;

	// Configuration register indexes
	localparam logic [2:0] REG_MIN_DELAY   = 3'd0;
	localparam logic [2:0] REG_SWEEP_DEPTH = 3'd1;
	localparam logic [2:0] REG_LFO_STEP    = 3'd2;
	localparam logic [2:0] REG_STEREO_OFS  = 3'd3;
	localparam logic [2:0] REG_FB_GAIN     = 3'd4;
	localparam logic [2:0] REG_WET_MIX     = 3'd5;

	// Angles in Q30 radians for the sine table
	localparam longint unsigned PI_Q30      = 64'd3373259426;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned TWO_PI_Q30  = 64'd6746518852;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SINE,
		ST_DEPTH,
		ST_RDREQ,
		ST_RDWAIT,
		ST_RD1,
		ST_INTERP,
		ST_MIX,
		ST_FB,
		ST_NEXTCH,
		ST_WRITE,
		ST_OUT
	} sfl_state_t;

	// Q1.15 sine, 1024 entries: integer Taylor series in Q30, rounded, capped to 32767.
	// Evaluated at elaboration only.
	function automatic logic signed [15:0] sine_lookup(input int k);
		longint unsigned a, x2, term;
		longint sum, q;
		logic neg;
		a = (TWO_PI_Q30 * 64'(k)) / 64'd1024;
		neg = 1'b0;
		if (a >= PI_Q30) begin
			neg = 1'b1;
			a = a - PI_Q30;
		end
		if (a > HALF_PI_Q30) a = PI_Q30 - a;
		x2 = (a * a) >> 30;
		term = a;
		sum = longint'(a);
		for (int n = 1; n <= 6; n++) begin
			term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n[0]) sum = sum - longint'(term);
			else sum = sum + longint'(term);
		end
		if (sum < 0) sum = 0;
		q = (sum + 64'sd16384) >>> 15;
		if (q > 64'sd32767) q = 64'sd32767;
		return neg ? 16'(-q) : 16'(q);
	endfunction

endpackage
`default_nettype wire

// ----- hdl/sfl_ram.sv -----
// Generic single-port RAM with registered read.
`default_nettype none
module sfl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] addr,
	input  wire  [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

// ----- hdl/stereo_flanger_core.sv -----
// Stereo flanger: top level with sequencer, shared multiplier and two delay lines.
//
// From acceptance of a stereo pair to a valid result, per channel a sequencer runs
// sine lookup, depth scaling, two reads of the single delay-line port,
// interpolation, mix and feedback through one shared 18x21 multiplier, then both
// lines are written in the same cycle. in_ready is high only in idle; the next pair
// can be taken in the cycle after the result is accepted, so no new pair is taken
// while one is in flight. After reset a clearing pass zeroes all 4096 entries of both
// lines; no item is taken meanwhile.
`default_nettype none
module stereo_flanger_core (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  wire sfl_pkg::sfl_in_t in_data,
	output logic              out_valid,
	input  wire               out_ready,
	output sfl_pkg::sfl_out_t out_data,
	input  wire               cfg_valid,
	output logic              cfg_ready,
	input  wire  [2:0]        cfg_index,
	input  wire  [23:0]       cfg_data
);
	localparam int AW = 12;

	// configuration
	logic [19:0] min_delay_q, sweep_depth_q;
	logic [23:0] lfo_step_q, stereo_ofs_q, lfo_acc_q;
	logic signed [15:0] fb_gain_q;
	logic [15:0] wet_mix_q;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_delay_q   <= 20'd256;
			sweep_depth_q <= 20'd512;
			lfo_step_q    <= 24'd1024;
			stereo_ofs_q  <= '0;
			fb_gain_q     <= 16'sd16384;
			wet_mix_q     <= 16'd16384;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sfl_pkg::REG_MIN_DELAY:   min_delay_q   <= cfg_data[19:0];
				sfl_pkg::REG_SWEEP_DEPTH: sweep_depth_q <= cfg_data[19:0];
				sfl_pkg::REG_LFO_STEP:    lfo_step_q    <= cfg_data;
				sfl_pkg::REG_STEREO_OFS:  stereo_ofs_q  <= cfg_data;
				sfl_pkg::REG_FB_GAIN:     fb_gain_q     <= cfg_data[15:0];
				sfl_pkg::REG_WET_MIX:     wet_mix_q     <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	sfl_pkg::sfl_state_t state_q, state_d;
	logic        ch_q;               // 0 left, 1 right
	logic [AW-1:0] wp_q, clr_q, i0_q;
	logic [7:0]  f_q;
	logic signed [15:0] sin_q, in_l_q, in_r_q, e0_q, e1_q, dly_q;
	logic signed [15:0] out_l_q, out_r_q, st_l_q, st_r_q;
	logic [19:0] d_q;
	logic signed [40:0] prod;
	logic signed [17:0] mul_a;
	logic signed [20:0] mul_b;
	logic signed [15:0] cur_in;
	logic [23:0] phase;
	logic [15:0] wet_eff;

	assign cur_in  = ch_q ? in_r_q : in_l_q;
	assign phase   = ch_q ? lfo_acc_q + stereo_ofs_q : lfo_acc_q;
	assign wet_eff = (wet_mix_q > 16'd32768) ? 16'd32768 : wet_mix_q;

	// constant sine table
	logic [1023:0][15:0] sine_rom;
	for (genvar k = 0; k < 1024; k++) begin : g_sine
		localparam logic signed [15:0] SINE_V = sfl_pkg::sine_lookup(k);
		assign sine_rom[k] = SINE_V;
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			sfl_pkg::ST_DEPTH: begin
				mul_a = 18'(signed'({1'b0, 17'(sin_q + 17'sd32768)}));
				mul_b = signed'({1'b0, sweep_depth_q});
			end
			sfl_pkg::ST_INTERP: begin
				mul_a = 18'(e1_q - e0_q);
				mul_b = 21'(signed'({1'b0, f_q}));
			end
			sfl_pkg::ST_MIX: begin
				mul_a = 18'(dly_q - cur_in);
				mul_b = 21'(signed'({1'b0, wet_eff}));
			end
			sfl_pkg::ST_FB: begin
				mul_a = 18'(dly_q);
				mul_b = 21'(fb_gain_q);
			end
			default: ;
		endcase
	end
	assign prod = 41'(mul_a) * 41'(mul_b);

	function automatic logic signed [15:0] sat16(input logic signed [25:0] v);
		if (v > 26'sd32767) return 16'sh7fff;
		if (v < -26'sd32768) return 16'sh8000;
		return v[15:0];
	endfunction

	// delay computation and tap position
	logic [20:0] d_sum;
	logic [19:0] d_cl, p;
	logic signed [25:0] mix_v, fb_v, itp_v;
	assign d_sum = 21'(min_delay_q) + 21'(prod[35:16]);
	assign d_cl  = (d_sum > 21'(20'hFFF00)) ? 20'hFFF00 : d_sum[19:0];
	assign p     = {wp_q, 8'd0} - d_q;
	assign itp_v = 26'(e0_q) + 26'(prod >>> 8);
	assign mix_v = 26'(cur_in) + 26'(prod >>> 15);
	assign fb_v  = 26'(cur_in) + 26'(prod >>> 15);

	// delay lines
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [15:0]   ram_wl, ram_wr, ram_rl, ram_rr;
	logic signed [15:0] rd;
	assign rd = ch_q ? ram_rr : ram_rl;
	sfl_ram #(.WIDTH(16), .DEPTH(4096)) u_left (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wl), .rdata(ram_rl));
	sfl_ram #(.WIDTH(16), .DEPTH(4096)) u_right (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wr), .rdata(ram_rr));

	// next state and memory control
	always_comb begin
		state_d  = state_q;
		ram_we   = 1'b0;
		ram_addr = i0_q;
		ram_wl   = st_l_q;
		ram_wr   = st_r_q;
		unique case (state_q)
			sfl_pkg::ST_CLEAR: begin
				ram_we = 1'b1; ram_addr = clr_q; ram_wl = '0; ram_wr = '0;
				if (clr_q == AW'(4095)) state_d = sfl_pkg::ST_IDLE;
			end
			sfl_pkg::ST_IDLE:   if (in_valid) state_d = sfl_pkg::ST_SINE;
			sfl_pkg::ST_SINE:   state_d = sfl_pkg::ST_DEPTH;
			sfl_pkg::ST_DEPTH:  state_d = sfl_pkg::ST_RDREQ;
			sfl_pkg::ST_RDREQ: begin
				ram_addr = p[19:8];
				state_d = sfl_pkg::ST_RDWAIT;
			end
			sfl_pkg::ST_RDWAIT: begin
				ram_addr = i0_q + AW'(1);
				state_d = sfl_pkg::ST_RD1;
			end
			sfl_pkg::ST_RD1:    state_d = sfl_pkg::ST_INTERP;
			sfl_pkg::ST_INTERP: state_d = sfl_pkg::ST_MIX;
			sfl_pkg::ST_MIX:    state_d = sfl_pkg::ST_FB;
			sfl_pkg::ST_FB:     state_d = sfl_pkg::ST_NEXTCH;
			sfl_pkg::ST_NEXTCH: state_d = ch_q ? sfl_pkg::ST_WRITE : sfl_pkg::ST_SINE;
			sfl_pkg::ST_WRITE: begin
				ram_we = 1'b1; ram_addr = wp_q;
				state_d = sfl_pkg::ST_OUT;
			end
			sfl_pkg::ST_OUT:    if (out_ready) state_d = sfl_pkg::ST_IDLE;
			default:            state_d = sfl_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfl_pkg::ST_CLEAR;
			clr_q <= '0; wp_q <= '0; lfo_acc_q <= '0; ch_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == sfl_pkg::ST_CLEAR) clr_q <= clr_q + AW'(1);
			if (state_q == sfl_pkg::ST_IDLE) ch_q <= 1'b0;
			if (state_q == sfl_pkg::ST_NEXTCH) ch_q <= 1'b1;
			if (state_q == sfl_pkg::ST_WRITE) begin
				wp_q <= wp_q + AW'(1);
				lfo_acc_q <= lfo_acc_q + lfo_step_q;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			sfl_pkg::ST_IDLE: begin
				in_l_q <= in_data.left_in; in_r_q <= in_data.right_in;
			end
			sfl_pkg::ST_SINE:   sin_q <= sine_rom[phase[23:14]];
			sfl_pkg::ST_DEPTH:  d_q <= d_cl;
			sfl_pkg::ST_RDREQ: begin i0_q <= p[19:8]; f_q <= p[7:0]; end
			sfl_pkg::ST_RDWAIT: e0_q <= rd;
			sfl_pkg::ST_RD1:    e1_q <= rd;
			sfl_pkg::ST_INTERP: dly_q <= itp_v[15:0];
			sfl_pkg::ST_MIX:
				if (ch_q) out_r_q <= sat16(mix_v); else out_l_q <= sat16(mix_v);
			sfl_pkg::ST_FB:
				if (ch_q) st_r_q <= sat16(fb_v); else st_l_q <= sat16(fb_v);
			default: ;
		endcase
	end

	assign in_ready  = (state_q == sfl_pkg::ST_IDLE);
	assign out_valid = (state_q == sfl_pkg::ST_OUT);
	assign out_data.left_out  = out_l_q;
	assign out_data.right_out = out_r_q;

	// checks
	a_excl: assert property (@(posedge clk) disable iff (!arst_n) !(in_ready && out_valid))
		else $error("ready and valid together");
	a_wp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sfl_pkg::ST_WRITE |=> wp_q == $past(wp_q) + AW'(1))
		else $error("write pointer did not advance");
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped");
endmodule
`default_nettype wire
